@@ hw/rtl/baro_temp_pressure_compensation_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i; BTPC_ASSERT is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_MACROS_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_MACROS_SVH

// clocked assertion, disabled while in reset
`define BTPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked assertion that also holds during reset
`define BTPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ hw/rtl/btpc_pkg.sv @@
// ----------------------------------------------------------------------------
// btpc_pkg
// Types and constants of the barometric compensation pipeline.
// ----------------------------------------------------------------------------
package btpc_pkg;

  localparam int unsigned TempStages = 5;
  localparam int unsigned PreStages  = 6;
  localparam int unsigned DivBits    = 64;
  localparam int unsigned PostStages = 5;
  localparam int unsigned Latency    = TempStages + PreStages + DivBits + PostStages;

  localparam logic [1:0] CfgTempTrim  = 2'd0;
  localparam logic [1:0] CfgPressLow  = 2'd1;
  localparam logic [1:0] CfgPressMid  = 2'd2;
  localparam logic [1:0] CfgPressHigh = 2'd3;

  localparam logic signed [35:0] CentiRound = 36'sd128;
  localparam logic signed [32:0] FineOffset = 33'sd128000;
  localparam logic [20:0]        PressBase  = 21'd1048576;
  localparam logic signed [63:0] NumScale   = 64'sd3125;
  localparam logic signed [63:0] DenBias    = 64'sh0000_8000_0000_0000;
  localparam int unsigned        P4Shift    = 35;
  localparam int unsigned        DenShift   = 33;

  typedef struct packed {
    logic [31:0] centi;
    logic [31:0] fine;
  } btpc_side_t;

  typedef struct packed {
    logic [63:0] num;
    logic [63:0] den;
    logic        neg;
    logic        zero;
    btpc_side_t  side;
  } btpc_div_t;

endpackage

@@ hw/rtl/btpc_temp.sv @@
// ----------------------------------------------------------------------------
// btpc_temp
// Temperature compensation stages: fine value, centi degrees, pressure offset.
// ----------------------------------------------------------------------------
module btpc_temp (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic [19:0]             raw_temperature_i,
  input  logic [19:0]             raw_pressure_i,
  input  logic [47:0]             temperature_trim_i,
  output logic                    valid_o,
  output btpc_pkg::btpc_side_t    side_o,
  output logic signed [32:0]      v1_o,
  output logic [19:0]             raw_pressure_o
);

  logic [15:0]        t1;
  logic signed [15:0] t2, t3;
  logic [4:0]         vld_q;
  logic [19:0]        ap_q [5];

  logic signed [17:0] a_d, a_q;
  logic signed [16:0] b_d, b_q;
  logic signed [33:0] m1_d, m1_q, m1b_q, bb_d, bb_q;
  logic signed [37:0] m2_d, m2_q;
  logic signed [31:0] fine_d, fine_q;
  logic signed [35:0] fine5;
  logic signed [31:0] centi_d;
  logic signed [32:0] v1_d;
  btpc_pkg::btpc_side_t side_q;
  logic signed [32:0] v1_q;

  assign t1 = temperature_trim_i[15:0];
  assign t2 = $signed(temperature_trim_i[31:16]);
  assign t3 = $signed(temperature_trim_i[47:32]);

  always_comb begin
    a_d     = $signed({1'b0, raw_temperature_i[19:3]}) - $signed({1'b0, t1, 1'b0});
    b_d     = $signed({1'b0, raw_temperature_i[19:4]}) - $signed({1'b0, t1});
    m1_d    = 34'(a_q) * 34'(t2);
    bb_d    = 34'(b_q) * 34'(b_q);
    m2_d    = 38'(bb_q >>> 12) * 38'(t3);
    fine_d  = 32'(m1b_q >>> 11) + 32'(m2_q >>> 14);
    fine5   = (36'(fine_q) <<< 2) + 36'(fine_q) + btpc_pkg::CentiRound;
    centi_d = 32'(fine5 >>> 8);
    v1_d    = 33'(fine_q) - btpc_pkg::FineOffset;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    a_q          <= a_d;
    b_q          <= b_d;
    m1_q         <= m1_d;
    bb_q         <= bb_d;
    m1b_q        <= m1_q;
    m2_q         <= m2_d;
    fine_q       <= fine_d;
    side_q.centi <= centi_d;
    side_q.fine  <= fine_q;
    v1_q         <= v1_d;
    ap_q[0]      <= raw_pressure_i;
    for (int i = 1; i < 5; i++) begin
      ap_q[i] <= ap_q[i-1];
    end
  end

  assign valid_o        = vld_q[4];
  assign side_o         = side_q;
  assign v1_o           = v1_q;
  assign raw_pressure_o = ap_q[4];

endmodule

@@ hw/rtl/btpc_pre.sv @@
// ----------------------------------------------------------------------------
// btpc_pre
// Pressure stages ahead of the divider: numerator, divisor, sign split.
// ----------------------------------------------------------------------------
module btpc_pre (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  btpc_pkg::btpc_side_t    side_i,
  input  logic signed [32:0]      v1_i,
  input  logic [19:0]             raw_pressure_i,
  input  logic [63:0]             pressure_trim_low_i,
  input  logic [63:0]             pressure_trim_mid_i,
  output logic                    valid_o,
  output btpc_pkg::btpc_div_t     div_o
);

  logic [15:0]        p1;
  logic signed [15:0] p2, p3, p4, p5, p6;
  logic [5:0]         vld_q;
  btpc_pkg::btpc_side_t side_q [5];
  logic [19:0]        ap_q [3];

  logic signed [63:0] sq_d, sq_q, m5_d, m5_q, m5b_q, m2_d, m2_q, m2b_q;
  logic signed [63:0] sqp6_d, sqp6_q, sqp3_d, sqp3_q;
  logic signed [63:0] v2_d, v2_q, v1c_d, v1c_q;
  logic signed [63:0] dm_d, dm_q, numd_d, numd_q;
  logic signed [63:0] n_d, n_q, d1_d, d1_q;
  logic [20:0]        p0;
  btpc_pkg::btpc_div_t div_d, div_q;

  assign p1 = pressure_trim_low_i[15:0];
  assign p2 = $signed(pressure_trim_low_i[31:16]);
  assign p3 = $signed(pressure_trim_low_i[47:32]);
  assign p4 = $signed(pressure_trim_low_i[63:48]);
  assign p5 = $signed(pressure_trim_mid_i[15:0]);
  assign p6 = $signed(pressure_trim_mid_i[31:16]);

  always_comb begin
    sq_d   = 64'(v1_i) * 64'(v1_i);
    m5_d   = 64'(v1_i) * 64'(p5);
    m2_d   = 64'(v1_i) * 64'(p2);
    sqp6_d = sq_q * 64'(p6);
    sqp3_d = sq_q * 64'(p3);
    v2_d   = sqp6_q + (m5b_q <<< 17) + (64'(p4) <<< btpc_pkg::P4Shift);
    v1c_d  = (sqp3_q >>> 8) + (m2b_q <<< 12);
    p0     = btpc_pkg::PressBase - 21'(ap_q[2]);
    dm_d   = (btpc_pkg::DenBias + v1c_q) * $signed(64'(p1));
    numd_d = ($signed(64'(p0)) <<< 31) - v2_q;
    n_d    = numd_q * btpc_pkg::NumScale;
    d1_d   = dm_q >>> btpc_pkg::DenShift;
    div_d.num  = n_q[63] ? 64'(-n_q) : 64'(n_q);
    div_d.den  = d1_q[63] ? 64'(-d1_q) : 64'(d1_q);
    div_d.neg  = n_q[63] ^ d1_q[63];
    div_d.zero = (d1_q == 64'sd0);
    div_d.side = side_q[4];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q   <= sq_d;
    m5_q   <= m5_d;
    m2_q   <= m2_d;
    sqp6_q <= sqp6_d;
    sqp3_q <= sqp3_d;
    m5b_q  <= m5_q;
    m2b_q  <= m2_q;
    v2_q   <= v2_d;
    v1c_q  <= v1c_d;
    dm_q   <= dm_d;
    numd_q <= numd_d;
    n_q    <= n_d;
    d1_q   <= d1_d;
    div_q  <= div_d;
    side_q[0] <= side_i;
    for (int i = 1; i < 5; i++) begin
      side_q[i] <= side_q[i-1];
    end
    ap_q[0] <= raw_pressure_i;
    for (int i = 1; i < 3; i++) begin
      ap_q[i] <= ap_q[i-1];
    end
  end

  assign valid_o = vld_q[5];
  assign div_o   = div_q;

endmodule

@@ hw/rtl/btpc_div.sv @@
// ----------------------------------------------------------------------------
// btpc_div
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
// ----------------------------------------------------------------------------
`include "baro_temp_pressure_compensation_macros.svh"

module btpc_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  btpc_pkg::btpc_div_t     op_i,
  output logic                    valid_o,
  output btpc_pkg::btpc_div_t     op_o
);

  localparam int unsigned N = btpc_pkg::DivBits;

  logic [N-1:0]        vld_q;
  btpc_pkg::btpc_div_t stage_d [N];
  btpc_pkg::btpc_div_t stage_q [N];
  btpc_pkg::btpc_div_t src     [N];
  logic [63:0]         rem_d   [N];
  logic [63:0]         rem_q   [N];
  logic [64:0]         trial   [N];
  logic [64:0]         diff    [N];

  always_comb begin
    src[0]   = op_i;
    trial[0] = {64'd0, op_i.num[63]};
    for (int k = 1; k < N; k++) begin
      src[k]   = stage_q[k-1];
      trial[k] = {rem_q[k-1], stage_q[k-1].num[63]};
    end
    for (int k = 0; k < N; k++) begin
      diff[k]    = trial[k] - {1'b0, src[k].den};
      stage_d[k] = src[k];
      if (trial[k] >= {1'b0, src[k].den}) begin
        rem_d[k]       = diff[k][63:0];
        stage_d[k].num = {src[k].num[62:0], 1'b1};
      end else begin
        rem_d[k]       = trial[k][63:0];
        stage_d[k].num = {src[k].num[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[N-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < N; k++) begin
      stage_q[k] <= stage_d[k];
      rem_q[k]   <= rem_d[k];
    end
  end

  assign valid_o = vld_q[N-1];
  assign op_o    = stage_q[N-1];

  `BTPC_ASSERT(a_rem_below_den, (valid_o && !op_o.zero) |-> (rem_q[N-1] < op_o.den), "divider remainder not below divisor")
  `BTPC_ASSERT(a_div_latency, valid_o |-> $past(valid_i, N), "divider output without matching input")

endmodule

@@ hw/rtl/btpc_post.sv @@
// ----------------------------------------------------------------------------
// btpc_post
// Pressure stages after the divider: sign restore, P7..P9 terms, result reg.
// ----------------------------------------------------------------------------
module btpc_post (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  btpc_pkg::btpc_div_t     op_i,
  input  logic [63:0]             pressure_trim_mid_i,
  input  logic [15:0]             pressure_trim_high_i,
  output logic                    result_valid_o,
  output logic signed [31:0]      temperature_centi_o,
  output logic signed [31:0]      fine_temperature_o,
  output logic [31:0]             pressure_q24_8_o,
  output logic                    divisor_zero_o
);

  logic signed [15:0] p7, p8, p9;
  logic [4:0]         vld_q;
  btpc_pkg::btpc_side_t side_q [4];
  logic [3:0]         zero_q;

  logic signed [63:0] p_d, p_q, p1_q, p2_q, p3_q;
  logic signed [63:0] s_d, s_q, x_d, x_q, pm8_d, pm8_q;
  logic [63:0]        pp0_d, pp0_q, pp0b_q;
  logic [31:0]        pp1_d, pp1_q, pp1b_q, pp2_d, pp2_q, xh_q, sl_q;
  logic signed [63:0] v2_d, v2_q, v2b_q;
  logic [63:0]        prod;
  logic signed [63:0] res;
  logic signed [31:0] centi_q, fine_q;
  logic [31:0]        press_q;
  logic               dz_q;

  assign p7 = $signed(pressure_trim_mid_i[47:32]);
  assign p8 = $signed(pressure_trim_mid_i[63:48]);
  assign p9 = $signed(pressure_trim_high_i);

  always_comb begin
    p_d   = op_i.neg ? $signed(64'd0 - op_i.num) : $signed(op_i.num);
    s_d   = p_q >>> 13;
    x_d   = (p_q >>> 13) * 64'(p9);
    pm8_d = p_q * 64'(p8);
    pp0_d = 64'(x_q[31:0]) * 64'(s_q[31:0]);
    pp1_d = 32'(x_q[31:0] * s_q[63:32]);
    v2_d  = pm8_q >>> 19;
    pp2_d = 32'(xh_q * sl_q);
    prod  = pp0b_q + {32'(pp1b_q + pp2_q), 32'd0};
    res   = ((p3_q + ($signed(prod) >>> 25) + v2b_q) >>> 8) + (64'(p7) <<< 4);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    s_q    <= s_d;
    x_q    <= x_d;
    pm8_q  <= pm8_d;
    p1_q   <= p_q;
    pp0_q  <= pp0_d;
    pp1_q  <= pp1_d;
    v2_q   <= v2_d;
    xh_q   <= x_q[63:32];
    sl_q   <= s_q[31:0];
    p2_q   <= p1_q;
    pp0b_q <= pp0_q;
    pp1b_q <= pp1_q;
    pp2_q  <= pp2_d;
    v2b_q  <= v2_q;
    p3_q   <= p2_q;
    side_q[0] <= op_i.side;
    zero_q[0] <= op_i.zero;
    for (int i = 1; i < 4; i++) begin
      side_q[i] <= side_q[i-1];
      zero_q[i] <= zero_q[i-1];
    end
    centi_q <= $signed(side_q[3].centi);
    fine_q  <= $signed(side_q[3].fine);
    press_q <= zero_q[3] ? 32'd0 : res[31:0];
    dz_q    <= zero_q[3];
  end

  assign result_valid_o      = vld_q[4];
  assign temperature_centi_o = centi_q;
  assign fine_temperature_o  = fine_q;
  assign pressure_q24_8_o    = press_q;
  assign divisor_zero_o      = dz_q;

endmodule

@@ hw/rtl/baro_temp_pressure_compensation.sv @@
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation
// Integer temperature and pressure compensation of a barometric sensor.
// ----------------------------------------------------------------------------
// A transaction (raw temperature and raw pressure) is taken on every cycle
// that start is high; busy stays low, so one transaction per cycle is
// sustained. Each result appears on result_valid_o for one cycle, after
// 5 temperature stages, 6 pre-divide pressure stages, a 64-stage divider
// (one quotient bit per stage) and 5 final stages. Results cannot be held
// off. Trim registers are written through the cfg port and must not change
// while transactions are in flight.
// ----------------------------------------------------------------------------
`include "baro_temp_pressure_compensation_macros.svh"

module baro_temp_pressure_compensation (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [19:0]        raw_temperature_i,
  input  logic [19:0]        raw_pressure_i,
  output logic               result_valid_o,
  output logic signed [31:0] temperature_centi_o,
  output logic signed [31:0] fine_temperature_o,
  output logic [31:0]        pressure_q24_8_o,
  output logic               divisor_zero_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i
);

  logic [47:0] ttrim_q;
  logic [63:0] plow_q, pmid_q;
  logic [15:0] phigh_q;

  logic                 temp_vld, pre_vld, div_vld;
  btpc_pkg::btpc_side_t temp_side;
  logic signed [32:0]   temp_v1;
  logic [19:0]          temp_ap;
  btpc_pkg::btpc_div_t  pre_op, div_op;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttrim_q <= '0;
      plow_q  <= '0;
      pmid_q  <= '0;
      phigh_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        btpc_pkg::CfgTempTrim:  ttrim_q <= cfg_data_i[47:0];
        btpc_pkg::CfgPressLow:  plow_q  <= cfg_data_i;
        btpc_pkg::CfgPressMid:  pmid_q  <= cfg_data_i;
        btpc_pkg::CfgPressHigh: phigh_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  btpc_temp u_temp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .valid_i            (start && !busy),
    .raw_temperature_i  (raw_temperature_i),
    .raw_pressure_i     (raw_pressure_i),
    .temperature_trim_i (ttrim_q),
    .valid_o            (temp_vld),
    .side_o             (temp_side),
    .v1_o               (temp_v1),
    .raw_pressure_o     (temp_ap)
  );

  btpc_pre u_pre (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .valid_i             (temp_vld),
    .side_i              (temp_side),
    .v1_i                (temp_v1),
    .raw_pressure_i      (temp_ap),
    .pressure_trim_low_i (plow_q),
    .pressure_trim_mid_i (pmid_q),
    .valid_o             (pre_vld),
    .div_o               (pre_op)
  );

  btpc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pre_vld),
    .op_i    (pre_op),
    .valid_o (div_vld),
    .op_o    (div_op)
  );

  btpc_post u_post (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .valid_i              (div_vld),
    .op_i                 (div_op),
    .pressure_trim_mid_i  (pmid_q),
    .pressure_trim_high_i (phigh_q),
    .result_valid_o       (result_valid_o),
    .temperature_centi_o  (temperature_centi_o),
    .fine_temperature_o   (fine_temperature_o),
    .pressure_q24_8_o     (pressure_q24_8_o),
    .divisor_zero_o       (divisor_zero_o)
  );

  `BTPC_ASSERT(a_latency, result_valid_o |-> $past(start, btpc_pkg::Latency), "result without a transaction")
  `BTPC_ASSERT(a_zero_press, (result_valid_o && divisor_zero_o) |-> (pressure_q24_8_o == 32'd0), "zero divisor with nonzero pressure")
  `BTPC_ASSERT_ALWAYS(a_no_valid_in_reset, !rst_ni |-> !result_valid_o, "result strobe during reset")

endmodule
